FILE: src/idhsl_pkg.sv
// Shared types, constants and lookup functions for the id-hashed HSL color generator.
package idhsl_pkg;

  // Multiplicative hash constant and the full-scale value of the 24-bit hash fraction.
  localparam logic [31:0] HASH_MUL  = 32'd2654435761;
  localparam logic [23:0] FRAC_MAX  = 24'hFFFFFF;
  localparam logic [22:0] FRAC_HALF = 23'h7FFFFF;

  // One in Q16.
  localparam logic [16:0] Q_ONE = 17'd65536;

  // floor(v / 6) == (v * DIV6_MUL) >> 21 for every v below 2^19.
  localparam logic [18:0] DIV6_MUL = 19'd349526;

  // Saturations and lightness band limits in Q16.
  localparam logic [15:0] SAT_055 = 16'd36045;
  localparam logic [15:0] SAT_060 = 16'd39322;
  localparam logic [15:0] SAT_065 = 16'd42598;
  localparam logic [15:0] LQ_030  = 16'd19661;
  localparam logic [15:0] LQ_035  = 16'd22938;
  localparam logic [15:0] LQ_040  = 16'd26214;
  localparam logic [14:0] SPAN_035 = 15'd22938;
  localparam logic [14:0] SPAN_040 = 15'd26214;
  localparam logic [14:0] SPAN_045 = 15'd29491;

  // Object kinds.
  localparam logic [2:0] KIND_COMPONENT    = 3'd0;
  localparam logic [2:0] KIND_CONSTRUCTION = 3'd1;
  localparam logic [2:0] KIND_SUBSURFACE   = 3'd2;
  localparam logic [2:0] KIND_WINDOW       = 3'd3;
  localparam logic [2:0] KIND_GLAZING      = 3'd4;

  // Hue sectors of 60 degrees each.
  localparam logic [2:0] SEC_RED_YEL = 3'd0;
  localparam logic [2:0] SEC_YEL_GRN = 3'd1;
  localparam logic [2:0] SEC_GRN_CYN = 3'd2;
  localparam logic [2:0] SEC_CYN_BLU = 3'd3;
  localparam logic [2:0] SEC_BLU_MAG = 3'd4;
  localparam logic [2:0] SEC_MAG_RED = 3'd5;

  // A hue as its sector and the height of the secondary-channel triangle in tens of degrees
  // (60 - |hue mod 120 - 60|) / 10, which is 0..6.
  typedef struct packed {
    logic [2:0] sector;
    logic [2:0] tri_k;
  } hue_t;

  typedef struct packed {
    logic        black;
    hue_t        hue;
    logic [15:0] sat;
    logic [15:0] base;
    logic [14:0] span;
  } attr_t;

  typedef struct packed {
    logic        black;
    hue_t        hue;
    logic [15:0] sat;
    logic [15:0] lq;
  } light_t;

  typedef struct packed {
    logic        black;
    logic [2:0]  sector;
    logic [15:0] lq;
    logic [15:0] cq;
    logic [15:0] xq;
  } chroma_t;

  function automatic hue_t mk_hue(input logic [2:0] sector, input logic [2:0] tri_k);
    hue_t h;
    h.sector = sector;
    h.tri_k  = tri_k;
    return h;
  endfunction

  // Component and construction types: 0,20,210,40,60,30,260,120,140,180,100,300,320 degrees.
  function automatic hue_t comp_hue(input logic [3:0] code);
    hue_t h;
    unique case (code)
      4'd0:    h = mk_hue(SEC_RED_YEL, 3'd0);
      4'd1:    h = mk_hue(SEC_RED_YEL, 3'd2);
      4'd2:    h = mk_hue(SEC_CYN_BLU, 3'd3);
      4'd3:    h = mk_hue(SEC_RED_YEL, 3'd4);
      4'd4:    h = mk_hue(SEC_YEL_GRN, 3'd6);
      4'd5:    h = mk_hue(SEC_RED_YEL, 3'd3);
      4'd6:    h = mk_hue(SEC_BLU_MAG, 3'd2);
      4'd7:    h = mk_hue(SEC_GRN_CYN, 3'd0);
      4'd8:    h = mk_hue(SEC_GRN_CYN, 3'd2);
      4'd9:    h = mk_hue(SEC_CYN_BLU, 3'd6);
      4'd10:   h = mk_hue(SEC_YEL_GRN, 3'd2);
      4'd11:   h = mk_hue(SEC_MAG_RED, 3'd6);
      default: h = mk_hue(SEC_MAG_RED, 3'd4);
    endcase
    return h;
  endfunction

  // Subsurface types: 220,330,280 degrees, everything else 290.
  function automatic hue_t sub_hue(input logic [3:0] code);
    hue_t h;
    unique case (code)
      4'd0:    h = mk_hue(SEC_CYN_BLU, 3'd2);
      4'd1:    h = mk_hue(SEC_MAG_RED, 3'd3);
      4'd2:    h = mk_hue(SEC_BLU_MAG, 3'd4);
      default: h = mk_hue(SEC_BLU_MAG, 3'd5);
    endcase
    return h;
  endfunction

  function automatic attr_t attr_of(input logic [2:0] kind, input logic [3:0] code);
    attr_t a;
    a = '0;
    unique case (kind)
      KIND_COMPONENT: begin
        a.hue = comp_hue(code);
        a.sat = SAT_065; a.base = LQ_030; a.span = SPAN_045;
      end
      KIND_CONSTRUCTION: begin
        a.hue = comp_hue(code);
        a.sat = SAT_055; a.base = LQ_035; a.span = SPAN_040;
      end
      KIND_SUBSURFACE: begin
        a.hue = sub_hue(code);
        a.sat = SAT_060; a.base = LQ_035; a.span = SPAN_040;
      end
      KIND_WINDOW: begin
        a.hue = mk_hue(SEC_CYN_BLU, 3'd2);
        a.sat = SAT_060; a.base = LQ_035; a.span = SPAN_040;
      end
      KIND_GLAZING: begin
        a.hue = mk_hue(SEC_CYN_BLU, 3'd2);
        a.sat = SAT_055; a.base = LQ_040; a.span = SPAN_035;
      end
      default: begin
        a.black = 1'b1;
      end
    endcase
    return a;
  endfunction

endpackage

FILE: src/idhsl_if.sv
// Valid/ready channel interfaces for the object input and the color output.
interface idhsl_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [3:0]         type_code;
  logic signed [31:0] object_id;

  modport source (output valid, output kind, output type_code, output object_id, input ready);
  modport sink   (input valid, input kind, input type_code, input object_id, output ready);
endinterface

interface idhsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

FILE: src/idhsl_light.sv
// Stages 1 to 3: attribute lookup, id hash, and lightness placed inside the kind's band.
module idhsl_light (
  input  logic                clk,
  input  logic                rst_n,
  idhsl_in_if.sink            in_ch,
  output logic                lt_valid,
  input  logic                lt_ready,
  output idhsl_pkg::light_t   lt_data
);

  logic                v1_r, v2_r, v3_r;
  logic                en1, en2, en3;
  idhsl_pkg::attr_t    attr1_r, attr2_r;
  idhsl_pkg::attr_t    attr1_nxt;
  logic [31:0]         hash1_r, hash1_nxt;
  logic [38:0]         prod2_r, prod2_nxt;
  idhsl_pkg::light_t   lt3_r, lt3_nxt;
  logic [39:0]         y;
  logic [15:0]         q0;
  logic [24:0]         rem;
  logic [15:0]         q;

  assign en3 = !v3_r || lt_ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ch.ready = en1;

  assign attr1_nxt = idhsl_pkg::attr_of(in_ch.kind, in_ch.type_code);
  assign hash1_nxt = 32'($unsigned(in_ch.object_id) * idhsl_pkg::HASH_MUL);
  assign prod2_nxt = 39'(hash1_r[31:8]) * 39'(attr1_r.span);

  // Rounded division by 2^24-1: split at bit 24, fold the quotient back into the
  // remainder, and correct once.
  always_comb begin
    y   = {1'b0, prod2_r} + 40'(idhsl_pkg::FRAC_HALF);
    q0  = y[39:24];
    rem = {1'b0, y[23:0]} + 25'(q0);
    q   = (rem >= 25'(idhsl_pkg::FRAC_MAX)) ? q0 + 16'd1 : q0;
    lt3_nxt.black = attr2_r.black;
    lt3_nxt.hue   = attr2_r.hue;
    lt3_nxt.sat   = attr2_r.sat;
    lt3_nxt.lq    = attr2_r.base + q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_ch.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      attr1_r <= attr1_nxt;
      hash1_r <= hash1_nxt;
    end
    if (en2) begin
      attr2_r <= attr1_r;
      prod2_r <= prod2_nxt;
    end
    if (en3) begin
      lt3_r <= lt3_nxt;
    end
  end

  assign lt_valid = v3_r;
  assign lt_data  = lt3_r;

endmodule

FILE: src/idhsl_chroma.sv
// Stages 4 to 6: chroma from lightness and saturation, then the secondary channel.
module idhsl_chroma (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                lt_valid,
  output logic                lt_ready,
  input  idhsl_pkg::light_t   lt_data,
  output logic                ch_valid,
  input  logic                ch_ready,
  output idhsl_pkg::chroma_t  ch_data
);

  logic                v4_r, v5_r, v6_r;
  logic                en4, en5, en6;
  logic [16:0]         l2;
  logic [16:0]         l2_dev;
  logic [16:0]         tq;
  logic [32:0]         cprod;
  logic                black4_r, black5_r;
  idhsl_pkg::hue_t     hue4_r;
  logic [2:0]          sector5_r;
  logic [15:0]         lq4_r, lq5_r;
  logic [15:0]         cq4_r, cq5_r;
  logic [15:0]         cq4_nxt;
  logic [17:0]         vx5_r, vx5_nxt;
  logic [36:0]         xprod;
  idhsl_pkg::chroma_t  ch6_r, ch6_nxt;

  assign en6 = !v6_r || ch_ready;
  assign en5 = !v5_r || en6;
  assign en4 = !v4_r || en5;
  assign lt_ready = en4;

  // Chroma: (1 - |2L - 1|) * S, rounded.
  always_comb begin
    l2      = {lt_data.lq, 1'b0};
    l2_dev  = (l2 >= idhsl_pkg::Q_ONE) ? l2 - idhsl_pkg::Q_ONE : idhsl_pkg::Q_ONE - l2;
    tq      = idhsl_pkg::Q_ONE - l2_dev;
    cprod   = 33'(tq) * 33'(lt_data.sat) + 33'd32768;
    cq4_nxt = cprod[31:16];
  end

  // Secondary channel: round(C * k / 6) = floor((C * k + 3) / 6).
  assign vx5_nxt = 18'(19'(cq4_r) * 19'(hue4_r.tri_k)) + 18'd3;
  assign xprod   = 37'(vx5_r) * 37'(idhsl_pkg::DIV6_MUL);

  always_comb begin
    ch6_nxt.black  = black5_r;
    ch6_nxt.sector = sector5_r;
    ch6_nxt.lq     = lq5_r;
    ch6_nxt.cq     = cq5_r;
    ch6_nxt.xq     = xprod[36:21];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en4) v4_r <= lt_valid;
      if (en5) v5_r <= v4_r;
      if (en6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      black4_r <= lt_data.black;
      hue4_r   <= lt_data.hue;
      lq4_r    <= lt_data.lq;
      cq4_r    <= cq4_nxt;
    end
    if (en5) begin
      black5_r  <= black4_r;
      sector5_r <= hue4_r.sector;
      lq5_r     <= lq4_r;
      cq5_r     <= cq4_r;
      vx5_r     <= vx5_nxt;
    end
    if (en6) begin
      ch6_r <= ch6_nxt;
    end
  end

  assign ch_valid = v6_r;
  assign ch_data  = ch6_r;

endmodule

FILE: src/idhsl_rgb.sv
// Stage 7: sector mapping, lightness offset and rounding of each channel to a byte.
module idhsl_rgb (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ch_valid,
  output logic                ch_ready,
  input  idhsl_pkg::chroma_t  ch_data,
  idhsl_out_if.source         out_ch
);

  logic               en7;
  logic               v7_r;
  logic [7:0]         red_r, green_r, blue_r;
  logic [7:0]         red_nxt, green_nxt, blue_nxt;
  logic [15:0]        rc, gc, bc;
  logic signed [19:0] m2;

  // Takes a doubled channel value, clamps it to 0..1 and scales it to 0..255 half up.
  function automatic logic [7:0] to_byte(input logic signed [19:0] c2);
    logic [17:0] v;
    logic [26:0] sc;
    logic [9:0]  b;
    if (c2 < 20'sd0) begin
      v = '0;
    end else if (c2 > 20'sd131072) begin
      v = 18'd131072;
    end else begin
      v = c2[17:0];
    end
    sc = {1'b0, v, 8'd0} - 27'(v) + 27'd65536;
    b  = sc[26:17];
    return (b > 10'd255) ? 8'd255 : b[7:0];
  endfunction

  always_comb begin
    unique case (ch_data.sector)
      idhsl_pkg::SEC_RED_YEL: begin rc = ch_data.cq; gc = ch_data.xq; bc = '0; end
      idhsl_pkg::SEC_YEL_GRN: begin rc = ch_data.xq; gc = ch_data.cq; bc = '0; end
      idhsl_pkg::SEC_GRN_CYN: begin rc = '0; gc = ch_data.cq; bc = ch_data.xq; end
      idhsl_pkg::SEC_CYN_BLU: begin rc = '0; gc = ch_data.xq; bc = ch_data.cq; end
      idhsl_pkg::SEC_BLU_MAG: begin rc = ch_data.xq; gc = '0; bc = ch_data.cq; end
      idhsl_pkg::SEC_MAG_RED: begin rc = ch_data.cq; gc = '0; bc = ch_data.xq; end
      default:                begin rc = '0; gc = '0; bc = '0; end
    endcase
    m2 = $signed({3'b000, ch_data.lq, 1'b0}) - $signed({4'b0000, ch_data.cq});
    if (ch_data.black) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else begin
      red_nxt   = to_byte($signed({3'b000, rc, 1'b0}) + m2);
      green_nxt = to_byte($signed({3'b000, gc, 1'b0}) + m2);
      blue_nxt  = to_byte($signed({3'b000, bc, 1'b0}) + m2);
    end
  end

  assign en7 = !v7_r || out_ch.ready;
  assign ch_ready = en7;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r <= 1'b0;
    end else if (en7) begin
      v7_r <= ch_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en7) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_ch.valid = v7_r;
  assign out_ch.red   = red_r;
  assign out_ch.green = green_r;
  assign out_ch.blue  = blue_r;

endmodule

FILE: src/id_hashed_hsl_color_generator.sv
// Top level of the id-hashed HSL color generator: one RGB color per object.
//
// The input channel in_ch carries an object kind, a type code and a 32-bit object id;
// the output channel out_ch carries the red, green and blue bytes of its color. Both
// are valid/ready channels, and a transaction completes on a clock edge where valid
// and ready are both high. Every input transaction produces exactly one output
// transaction, in order. Kinds above the glazing system give black.
//
// The block is a seven-stage pipeline: hash multiply, band multiply, band division,
// chroma multiply, triangle product, divide by six, and the output register. A color
// is offered on out_ch once its object has passed through every stage.
// While out_ch.ready stays high, one object can be taken on every cycle, so the
// sustained rate is one color per cycle.
//
// Each stage holds a valid bit and loads whenever it is empty or the stage after it
// moves. When the receiver holds out_ch.ready low, the pipeline keeps filling its empty
// stages and then drops in_ch.ready; nothing is lost or repeated. Synchronous reset on
// rst_n empties all stages; there is no other state.
module id_hashed_hsl_color_generator (
  input  logic         clk,
  input  logic         rst_n,
  idhsl_in_if.sink     in_ch,
  idhsl_out_if.source  out_ch
);

  logic                lt_valid, lt_ready;
  idhsl_pkg::light_t   lt_data;
  logic                ch_valid, ch_ready;
  idhsl_pkg::chroma_t  ch_data;

  idhsl_light u_light (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .lt_valid (lt_valid),
    .lt_ready (lt_ready),
    .lt_data  (lt_data)
  );

  idhsl_chroma u_chroma (
    .clk      (clk),
    .rst_n    (rst_n),
    .lt_valid (lt_valid),
    .lt_ready (lt_ready),
    .lt_data  (lt_data),
    .ch_valid (ch_valid),
    .ch_ready (ch_ready),
    .ch_data  (ch_data)
  );

  idhsl_rgb u_rgb (
    .clk      (clk),
    .rst_n    (rst_n),
    .ch_valid (ch_valid),
    .ch_ready (ch_ready),
    .ch_data  (ch_data),
    .out_ch   (out_ch)
  );

endmodule

FILE: tb/tb_id_hashed_hsl_color_generator.sv
// Self-checking testbench for the id-hashed HSL color generator pipeline.
module tb_id_hashed_hsl_color_generator;
  timeunit 1ns;
  timeprecision 1ps;

  import idhsl_pkg::*;

  localparam int CLK_PERIOD   = 2;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD    = 300;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } color_t;

  logic clk;
  logic rst_n;

  idhsl_in_if  in_ch();
  idhsl_out_if out_ch();

  id_hashed_hsl_color_generator DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  color_t      expected_colors[$];
  int          error_count;
  int          cycle_count;
  bit          sender_gaps_on;
  bit          receiver_gaps_on;
  bit          long_hold_req;
  logic [31:0] corner_ids[6];

  initial clk = 1'b0;
  always #(CLK_PERIOD / 2) clk = ~clk;

  // Idle lengths: mostly short, now and then a long one.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70) return $urandom_range(3, 1);
    if (pick < 95) return $urandom_range(8, 4);
    return $urandom_range(60, 20);
  endfunction

  // Converts a doubled channel value to a byte, rounding half up.
  function automatic logic [7:0] channel_byte(input longint twice_val);
    longint v;
    if (twice_val < 0) twice_val = 0;
    if (twice_val > 131072) twice_val = 131072;
    v = (twice_val * 255 + 65536) >> 17;
    if (v > 255) v = 255;
    return v[7:0];
  endfunction

  function automatic color_t predict_color(input logic [2:0] kind, input logic [3:0] code,
                                           input logic [31:0] id);
    color_t      rgb;
    logic [31:0] scrambled;
    longint      hue_deg, sat, base, span, frac, light, dev, tone, chroma, second;
    longint      rem, height, red_c, green_c, blue_c, offset2;
    rgb = '0;
    if (kind > KIND_GLAZING) return rgb;

    hue_deg = 220;
    if (kind == KIND_COMPONENT || kind == KIND_CONSTRUCTION) begin
      case (code)
        4'd0:    hue_deg = 0;
        4'd1:    hue_deg = 20;
        4'd2:    hue_deg = 210;
        4'd3:    hue_deg = 40;
        4'd4:    hue_deg = 60;
        4'd5:    hue_deg = 30;
        4'd6:    hue_deg = 260;
        4'd7:    hue_deg = 120;
        4'd8:    hue_deg = 140;
        4'd9:    hue_deg = 180;
        4'd10:   hue_deg = 100;
        4'd11:   hue_deg = 300;
        default: hue_deg = 320;
      endcase
    end else if (kind == KIND_SUBSURFACE) begin
      case (code)
        4'd0:    hue_deg = 220;
        4'd1:    hue_deg = 330;
        4'd2:    hue_deg = 280;
        default: hue_deg = 290;
      endcase
    end

    case (kind)
      KIND_COMPONENT:    begin sat = SAT_065; base = LQ_030; span = SPAN_045; end
      KIND_CONSTRUCTION: begin sat = SAT_055; base = LQ_035; span = SPAN_040; end
      KIND_GLAZING:      begin sat = SAT_055; base = LQ_040; span = SPAN_035; end
      default:           begin sat = SAT_060; base = LQ_035; span = SPAN_040; end
    endcase

    scrambled = id * HASH_MUL;
    frac  = scrambled[31:8];
    light = base + (frac * span * 2 + 64'hFFFFFF) / (2 * 64'hFFFFFF);
    dev   = 2 * light - 65536;
    if (dev < 0) dev = -dev;
    tone   = 65536 - dev;
    chroma = (tone * sat + 32768) >> 16;

    rem    = hue_deg % 120;
    height = 60 - ((rem >= 60) ? rem - 60 : 60 - rem);
    second = (chroma * height * 2 + 60) / 120;

    case (hue_deg / 60)
      0:       begin red_c = chroma; green_c = second; blue_c = 0;      end
      1:       begin red_c = second; green_c = chroma; blue_c = 0;      end
      2:       begin red_c = 0;      green_c = chroma; blue_c = second; end
      3:       begin red_c = 0;      green_c = second; blue_c = chroma; end
      4:       begin red_c = second; green_c = 0;      blue_c = chroma; end
      default: begin red_c = chroma; green_c = 0;      blue_c = second; end
    endcase

    offset2   = 2 * light - chroma;
    rgb.red   = channel_byte(2 * red_c + offset2);
    rgb.green = channel_byte(2 * green_c + offset2);
    rgb.blue  = channel_byte(2 * blue_c + offset2);
    return rgb;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  // Records each accepted object and checks each accepted color against the oldest one.
  always @(posedge clk) begin
    color_t got;
    color_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_colors.insert(expected_colors.size(),
                               predict_color(in_ch.kind, in_ch.type_code, in_ch.object_id));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.red, out_ch.green, out_ch.blue};
        if (expected_colors.size() == 0) begin
          report_mismatch($sformatf("unexpected color %h %h %h", got.red, got.green, got.blue));
        end else begin
          want = expected_colors.pop_front();
          if (got.red !== want.red)
            report_mismatch($sformatf("red %h, want %h", got.red, want.red));
          if (got.green !== want.green)
            report_mismatch($sformatf("green %h, want %h", got.green, want.green));
          if (got.blue !== want.blue)
            report_mismatch($sformatf("blue %h, want %h", got.blue, want.blue));
        end
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b1;
      end else if (receiver_gaps_on && $urandom_range(3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (idle_length()) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("id_hashed_hsl_color_generator regression: fail");
    $finish;
  end

  // Called at a rising edge; returns at the edge where the transaction completed,
  // or after the idle gap that follows it.
  task automatic send_object(input logic [2:0] kind, input logic [3:0] code,
                             input logic [31:0] id);
    in_ch.valid     <= 1'b1;
    in_ch.kind      <= kind;
    in_ch.type_code <= code;
    in_ch.object_id <= id;
    do @(posedge clk); while (!in_ch.ready);
    if (sender_gaps_on && $urandom_range(2) == 0) begin
      in_ch.valid <= 1'b0;
      repeat (idle_length()) @(posedge clk);
    end
  endtask

  task automatic send_random_object();
    logic [2:0]  kind;
    logic [31:0] id;
    kind = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(4));
    id   = ($urandom_range(15) == 0) ? corner_ids[$urandom_range(5)] : $urandom;
    send_object(kind, 4'($urandom_range(15)), id);
  endtask

  // Waits for a clock edge first, so that a transaction taken at the calling edge is already recorded.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_reset();
    logic [31:0] inv;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.kind      = '0;
    in_ch.type_code = '0;
    in_ch.object_id = '0;
    // Inverse of the hash multiplier, so that ids with chosen hash fractions can be built.
    inv = HASH_MUL;
    repeat (5) inv = inv * (32'd2 - HASH_MUL * inv);
    corner_ids[0] = 32'h0000_0000;
    corner_ids[1] = 32'hFFFF_FFFF;
    corner_ids[2] = 32'h7FFF_FFFF;
    corner_ids[3] = 32'h8000_0000;
    corner_ids[4] = 32'hFFFF_FFFF * inv;
    corner_ids[5] = 32'h8000_0000 * inv;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Every component type, unknown codes included, across the id corners.
  task automatic test_component_hues();
    for (int code = 0; code < 16; code++)
      send_object(KIND_COMPONENT, 4'(code), corner_ids[code % 6]);
  endtask

  // Construction with an unknown code, subsurface types, window, glazing and unknown kinds.
  task automatic test_other_kinds();
    send_object(KIND_CONSTRUCTION, 4'd13, corner_ids[4]);
    for (int code = 0; code < 4; code++)
      send_object(KIND_SUBSURFACE, 4'(code), corner_ids[code + 1]);
    send_object(KIND_SUBSURFACE, 4'd12, corner_ids[5]);
    send_object(KIND_WINDOW, 4'd7, corner_ids[4]);
    send_object(KIND_GLAZING, 4'd15, corner_ids[0]);
    for (int kind = KIND_GLAZING + 1; kind < 8; kind++)
      send_object(3'(kind), 4'($urandom_range(15)), $urandom);
  endtask

  task automatic test_random_traffic(input int count);
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    repeat (count) send_random_object();
  endtask

  task automatic test_back_to_back(input int count);
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    repeat (count) send_random_object();
  endtask

  // The receiver stops for a long stretch while objects keep coming, so the pipeline
  // fills and must stall its input.
  task automatic test_output_hold();
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b1;
    long_hold_req    = 1'b1;
    repeat (60) send_random_object();
  endtask

  task automatic test_sender_pause();
    sender_gaps_on   = 1'b1;
    receiver_gaps_on = 1'b1;
    repeat (30) send_random_object();
    wait_drained();
    repeat (30) send_random_object();
  endtask

  initial begin
    error_count      = 0;
    sender_gaps_on   = 1'b0;
    receiver_gaps_on = 1'b0;
    long_hold_req    = 1'b0;
    run_reset();
    test_component_hues();
    test_other_kinds();
    test_random_traffic(400);
    test_back_to_back(150);
    test_output_hold();
    test_sender_pause();
    test_random_traffic(180);
    wait_drained();
    if (error_count == 0) begin
      $display("id_hashed_hsl_color_generator regression: pass");
    end else begin
      $display("id_hashed_hsl_color_generator regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/idhsl_pkg.sv
src/idhsl_if.sv
src/idhsl_light.sv
src/idhsl_chroma.sv
src/idhsl_rgb.sv
src/id_hashed_hsl_color_generator.sv
tb/tb_id_hashed_hsl_color_generator.sv
